/* rtl/core/maf_pkg.sv */
package maf_pkg;

  localparam int DATA_W         = 16;
  localparam int WIN_W          = 9;
  localparam int MAX_WINDOW_DEF = 256;
  localparam int RESET_WINDOW   = 16;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  // store address width for a given window capacity
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // running sum width: 16-bit samples plus growth for the full store
  function automatic int sum_w(input int depth);
    return DATA_W + 1 + addr_w(depth);
  endfunction

  typedef struct packed {
    logic cfg_write;
    logic capture;
    logic pre_step;
    logic rd;
    logic upd;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pre_last;
    logic out_busy;
  } dp_stat_t;

endpackage

/* rtl/core/maf_if.sv */
interface maf_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic signed [maf_pkg::DATA_W-1:0] sample_value;

  modport source (output valid, output command, output sample_value, input ready);
  modport sink   (input valid, input command, input sample_value, output ready);
endinterface

interface maf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [maf_pkg::DATA_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

interface maf_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [maf_pkg::WIN_W-1:0]  window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface

/* rtl/core/maf_ram.sv */
module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/maf_ctrl.sv */
module maf_ctrl #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_command,
  output logic               in_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  maf_pkg::dp_stat_t  stat,
  output maf_pkg::ctrl_cmd_t cmd
);

  localparam int SW = maf_pkg::sum_w(MAX_WINDOW);
  localparam int CW = $clog2(SW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // config has priority over a new request in idle
  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.cfg_write = cfg_valid;
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_command == maf_pkg::CMD_PRELOAD) ? S_PRE : S_RD;
        end
      end
      S_PRE: begin
        cmd.pre_step = 1'b1;
        if (stat.pre_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(SW - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cfg_not_with_request: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cfg_write |-> !cmd.capture)
    else $error("config write and request capture in one cycle");

  a_sample_reaches_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.capture && in_command == maf_pkg::CMD_SAMPLE) |=> ##2 (state_r == S_DIV))
    else $error("sample request did not reach divider");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CW'(SW)))
    else $error("divider step count overran");
`endif

endmodule

/* rtl/core/maf_dp.sv */
module maf_dp #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  maf_pkg::ctrl_cmd_t                cmd,
  output maf_pkg::dp_stat_t                 stat,
  input  logic signed [maf_pkg::DATA_W-1:0] sample_value,
  input  logic [maf_pkg::WIN_W-1:0]         window_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [maf_pkg::DATA_W-1:0] average
);

  localparam int DW  = maf_pkg::DATA_W;
  localparam int WW  = maf_pkg::WIN_W;
  localparam int AW  = maf_pkg::addr_w(MAX_WINDOW);
  localparam int SW  = maf_pkg::sum_w(MAX_WINDOW);
  localparam int CW  = (AW > WW) ? AW + 1 : WW + 1;
  localparam int RST_WIN = (maf_pkg::RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW
                                                                : maf_pkg::RESET_WINDOW;

  logic [WW-1:0]          win_r, win_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [WW-1:0]          fill_r, fill_nxt;
  logic signed [SW-1:0]   sum_r, sum_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [DW-1:0]   val_r;
  logic [AW-1:0]          pre_idx_r;
  logic [WW-1:0]          rem_r;
  logic [SW-1:0]          quo_r;
  logic                   neg_r;
  logic signed [DW-1:0]   avg_r;

  logic [AW-1:0]          wp_eff;
  logic [CW-1:0]          wp_inc;
  logic                   full;
  logic signed [DW-1:0]   old_sample;
  logic signed [SW-1:0]   sum_upd;
  logic signed [DW+WW:0]  pre_prod;
  logic [SW-1:0]          sum_mag;
  logic [WW:0]            shifted;
  logic [WW+1:0]          diff;
  logic [WW-1:0]          len_sat;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DW-1:0]          ram_rdata;

  // stale position past the window wraps to the start
  assign wp_eff = (CW'(wp_r) >= CW'(win_r)) ? '0 : wp_r;
  assign wp_inc = CW'(wp_eff) + CW'(1);
  assign full   = (fill_r == win_r);

  assign old_sample = $signed(ram_rdata);
  assign sum_upd    = sum_r + SW'(val_r) - (full ? SW'(old_sample) : SW'(0));
  assign pre_prod   = val_r * $signed({1'b0, win_r});
  assign sum_mag    = sum_upd[SW-1] ? SW'(-sum_upd) : SW'(sum_upd);

  // restoring divide step, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[SW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, fill_r};

  assign len_sat = (int'(window_length) > MAX_WINDOW) ? WW'(MAX_WINDOW) : window_length;

  assign stat.pre_last = (CW'(pre_idx_r) == CW'(win_r) - CW'(1));
  assign stat.out_busy = out_valid_r;

  assign ram_we    = cmd.pre_step || cmd.upd;
  assign ram_waddr = cmd.pre_step ? pre_idx_r : wp_eff;

  maf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val_r),
    .re    (cmd.rd),
    .raddr (wp_eff),
    .rdata (ram_rdata)
  );

  always_comb begin
    win_nxt       = win_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
    if (cmd.cfg_write) begin
      if (window_length != '0) begin
        win_nxt  = len_sat;
        wp_nxt   = '0;
        fill_nxt = '0;
        sum_nxt  = '0;
      end
    end else if (cmd.pre_step) begin
      sum_nxt  = SW'(pre_prod);
      fill_nxt = win_r;
      wp_nxt   = '0;
    end else if (cmd.upd) begin
      sum_nxt  = sum_upd;
      fill_nxt = full ? fill_r : fill_r + WW'(1);
      wp_nxt   = (wp_inc >= CW'(win_r)) ? '0 : AW'(wp_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WW'(RST_WIN);
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_r     <= sample_value;
      pre_idx_r <= '0;
    end else if (cmd.pre_step) begin
      pre_idx_r <= pre_idx_r + AW'(1);
    end
    if (cmd.upd) begin
      rem_r <= '0;
      quo_r <= sum_mag;
      neg_r <= sum_upd[SW-1];
    end else if (cmd.div_step) begin
      if (!diff[WW+1]) begin
        rem_r <= diff[WW-1:0];
        quo_r <= {quo_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[WW-1:0];
        quo_r <= {quo_r[SW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      avg_r <= neg_r ? -$signed(quo_r[DW-1:0]) : $signed(quo_r[DW-1:0]);
    end
  end

  assign out_valid = out_valid_r;
  assign average   = avg_r;

`ifndef SYNTHESIS
  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r)
    else $error("fill count exceeds window");

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(wp_r) < CW'(win_r))
    else $error("write position outside window");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> (fill_r != '0))
    else $error("divide by zero fill count");
`endif

endmodule

/* rtl/core/moving_average_filter_unit.sv */
// Moving average over a circular sample store with a serial divider.
// Sample request: store read, sum update, then the bit-per-cycle divider over the SW-bit
//   running sum, and the result is loaded.
// Preload request: one store write per cycle across the window, no result.
// One request at a time; a new one is accepted while the last result still waits.
// Reset (rst_n, synchronous): window 16, sum, fill and position cleared.
module moving_average_filter_unit #(
  parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  maf_in_if.sink           in_chan,
  maf_out_if.source        out_chan,
  maf_cfg_if.sink          cfg_chan
);

  // Controller sequences each request:
  //   sample : read oldest entry, update sum/fill/position, divide, load output
  //   preload: sweep the window writing the value, sum = value * window
  // Config writes are taken only in idle; a nonzero length clears the window state.

  maf_pkg::ctrl_cmd_t cmd;
  maf_pkg::dp_stat_t  stat;

  maf_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .cfg_valid  (cfg_chan.valid),
    .cfg_ready  (cfg_chan.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: window register, running sum, store, divider, output register.
  maf_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .sample_value  (in_chan.sample_value),
    .window_length (cfg_chan.window_length),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .average       (out_chan.average)
  );

endmodule

/* test/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Window capacity of the instance; the predictor store is sized to match.
  localparam int MAX_WIN = maf_pkg::MAX_WINDOW_DEF;

  // A preload request walks the whole window, one write per cycle, and
  // leaves nothing in the result queue. Give it room before any register write.
  localparam int SETTLE_CYCLES = MAX_WIN + 40;

  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 400;

  // Watchdog: cycles without any accepted request, result or register write.
  localparam int STALL_LIMIT = 5000;

  localparam int N_SEG     = 8;
  localparam int SEG_ITEMS = 156;
  localparam int HOLD_SEG  = 6;
  localparam int PAUSE_SEG = 2;

  typedef enum logic {ROW_REQ, ROW_WIN} row_kind_t;

  // One line of the directed table. A ROW_WIN line writes the window length;
  // a ROW_REQ line sends one request, and where typed is set the result is
  // the hand-worked value instead of the predictor output.
  typedef struct {
    row_kind_t                  kind;
    logic                       cmd;
    logic signed [15:0]         value;
    logic [maf_pkg::WIN_W-1:0]  win;
    bit                         typed;
    logic signed [15:0]         avg;
  } dir_row_t;

  localparam int N_DIR = 26;

  dir_row_t dir_rows [N_DIR] = '{
    // reset window is 16; first sample averages over itself
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sh7FFF, 9'd0,   1'b1, 16'sh7FFF},
    // full-scale pair sums to -1, -1/2 truncates toward zero
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sh8000, 9'd0,   1'b1, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  -16'sd1,   9'd0,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sh5555, 9'd0,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'shAAAA, 9'd0,   1'b0, 16'sh0000},
    // preload fills the window; same value in keeps the average
    '{ROW_REQ, maf_pkg::CMD_PRELOAD, 16'sh7FFF, 9'd0,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sh7FFF, 9'd0,   1'b1, 16'sh7FFF},
    '{ROW_REQ, maf_pkg::CMD_PRELOAD, 16'sh8000, 9'd0,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sh8000, 9'd0,   1'b1, 16'sh8000},
    // -1/16 truncates to zero, not -1
    '{ROW_REQ, maf_pkg::CMD_PRELOAD, 16'sh0000, 9'd0,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  -16'sd1,   9'd0,   1'b1, 16'sh0000},
    // window of one: every result is the last sample
    '{ROW_WIN, maf_pkg::CMD_SAMPLE,  16'sh0000, 9'd1,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sh8000, 9'd0,   1'b1, 16'sh8000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sd12345, 9'd0,  1'b1, 16'sd12345},
    // zero length is dropped, window stays at one
    '{ROW_WIN, maf_pkg::CMD_SAMPLE,  16'sh0000, 9'd0,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  -16'sd7,   9'd0,   1'b1, -16'sd7},
    // all-ones length saturates to the capacity
    '{ROW_WIN, maf_pkg::CMD_SAMPLE,  16'sh0000, 9'd511, 1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_PRELOAD, 16'sh8000, 9'd0,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sh7FFF, 9'd0,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sd5,    9'd0,   1'b0, 16'sh0000},
    // just over the capacity, also saturates and clears
    '{ROW_WIN, maf_pkg::CMD_SAMPLE,  16'sh0000, 9'd257, 1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sd100,  9'd0,   1'b1, 16'sd100},
    // window of two: fill, then oldest drops out; -5/2 -> -2
    '{ROW_WIN, maf_pkg::CMD_SAMPLE,  16'sh0000, 9'd2,   1'b0, 16'sh0000},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sd3,    9'd0,   1'b1, 16'sd3},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  16'sd4,    9'd0,   1'b1, 16'sd3},
    '{ROW_REQ, maf_pkg::CMD_SAMPLE,  -16'sd9,   9'd0,   1'b1, -16'sd2}
  };

  // Window settings for the random segments; the last one is drawn at run time.
  logic [maf_pkg::WIN_W-1:0] seg_win [N_SEG] =
    '{9'd1, 9'd256, 9'd3, 9'd511, 9'd7, 9'd0, 9'd64, 9'd0};

  logic clk;
  logic rst_n;

  maf_in_if  in_if();
  maf_out_if out_if();
  maf_cfg_if cfg_if();

  moving_average_filter_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor: circular history, fill count and running sum.
  // ---------------------------------------------------------------------------
  logic signed [15:0] hist [MAX_WIN];
  int                 hist_pos;
  int                 hist_cnt;
  longint             hist_sum;
  int                 win_len;

  logic signed [15:0] pending_avgs [$];   // averages still owed by the block
  int                 err_cnt;

  function automatic void filter_clear();
    foreach (hist[i]) hist[i] = '0;
    hist_pos = 0;
    hist_cnt = 0;
    hist_sum = 0;
  endfunction

  // Zero length is dropped; anything above capacity saturates. Both real
  // writes clear the history.
  function automatic void filter_window_write(input logic [maf_pkg::WIN_W-1:0] len);
    if (len == '0) return;
    win_len = (int'(len) > MAX_WIN) ? MAX_WIN : int'(len);
    filter_clear();
  endfunction

  // Returns 1 when the request produces an average.
  function automatic bit filter_step(input logic cmd, input logic signed [15:0] val,
                                     output logic signed [15:0] avg);
    longint quot;
    avg = '0;
    if (cmd == maf_pkg::CMD_PRELOAD) begin
      for (int i = 0; i < win_len; i++) hist[i] = val;
      hist_sum = longint'(val) * win_len;
      hist_cnt = win_len;
      hist_pos = 0;
      return 1'b0;
    end
    if (hist_pos >= win_len) hist_pos = 0;
    // Once full, the oldest sample leaves the sum before the new one enters.
    if (hist_cnt < win_len) hist_cnt++;
    else hist_sum -= hist[hist_pos];
    hist[hist_pos] = val;
    hist_sum += val;
    hist_pos = (hist_pos + 1 >= win_len) ? 0 : hist_pos + 1;
    quot = hist_sum / hist_cnt;   // signed divide, truncates toward zero
    avg = quot[15:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: receiver idling, long hold-off, and the checker.
  // ---------------------------------------------------------------------------
  int rcv_idle_pct;
  int hold_seq;       // bumped by the stimulus to ask for a long hold-off
  int snd_idle_pct;

  initial begin : rcv_proc
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_avgs.size() == 0) begin
        $error("average: unexpected result %0d", out_if.average);
        err_cnt++;
      end else begin
        want = pending_avgs.pop_front();
        if (out_if.average !== want) begin
          $error("average: expected %0d, actual %0d", want, out_if.average);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: any accepted request, result or register write restarts it.
  int stall_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------------

  // Offers one request and returns at the edge it is taken, with valid
  // still high so a back-to-back request needs no extra edge.
  task automatic send_req(input logic cmd, input logic signed [15:0] val,
                          input bit typed = 1'b0,
                          input logic signed [15:0] typed_avg = '0);
    logic signed [15:0] avg;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= cmd;
    in_if.sample_value <= val;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (filter_step(cmd, val, avg)) pending_avgs.push_back(typed ? typed_avg : avg);
  endtask

  // Stops offering and waits until every owed average has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_avgs.size() != 0);
  endtask

  // Idle point for a register write: results drained, then room for a
  // trailing preload that owes nothing.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [maf_pkg::WIN_W-1:0] len);
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= len;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    filter_window_write(len);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly full-range values, with extremes and small values near zero so
  // negative sums hit the truncation often.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin : stim
    logic [maf_pkg::WIN_W-1:0] len;
    logic                      cmd;
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.command        <= maf_pkg::CMD_SAMPLE;
    in_if.sample_value   <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.window_length <= '0;
    rcv_idle_pct         <= 0;
    hold_seq             <= 0;
    snd_idle_pct = 0;
    err_cnt      = 0;
    win_len      = maf_pkg::RESET_WINDOW;
    filter_clear();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, no idling.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WIN) begin
        settle();
        write_window(dir_rows[r].win);
      end else begin
        send_req(dir_rows[r].cmd, dir_rows[r].value, dir_rows[r].typed, dir_rows[r].avg);
      end
    end

    // Random segments, one window setting each. Idling: sender light and
    // receiver heavy, then the reverse, then none at all.
    for (int s = 0; s < N_SEG; s++) begin
      settle();
      len = (s == N_SEG - 1) ? 9'($urandom_range(511)) : seg_win[s];
      write_window(len);
      if (s < 3) begin
        snd_idle_pct = 15;
        rcv_idle_pct <= 82;
      end else if (s < 6) begin
        snd_idle_pct = 82;
        rcv_idle_pct <= 15;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
      end
      // receiver backs off while the sender keeps pushing requests
      if (s == HOLD_SEG) hold_seq <= hold_seq + 1;
      for (int k = 0; k < SEG_ITEMS; k++) begin
        // sender stops mid-stream until the block has caught up
        if (s == PAUSE_SEG && k == SEG_ITEMS / 2) drain();
        cmd = ($urandom_range(99) < 4) ? maf_pkg::CMD_PRELOAD : maf_pkg::CMD_SAMPLE;
        send_req(cmd, pick_sample());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_cnt == 0 && pending_avgs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
